### hdl/hts_pkg.sv
// shared types, constants and lookup functions for the html tag stripper
// no dependencies; imported by hts_ctrl, hts_datapath and html_tag_stripper
`default_nettype none

package hts_pkg;

    localparam logic [7:0] CHAR_LT = 8'h3c;
    localparam logic [7:0] CHAR_GT = 8'h3e;

    localparam logic [8*11-1:0] OPENER_BQ     = "<blockquote";
    localparam logic [8*7-1:0]  OPENER_SCRIPT = "<script";
    localparam logic [8*6-1:0]  OPENER_STYLE  = "<style";
    localparam logic [8*13-1:0] CLOSER_BQ     = "</blockquote>";
    localparam logic [8*9-1:0]  CLOSER_SCRIPT = "</script>";
    localparam logic [8*8-1:0]  CLOSER_STYLE  = "</style>";

    localparam logic [1:0] KIND_BQ     = 2'd0;
    localparam logic [1:0] KIND_SCRIPT = 2'd1;
    localparam logic [1:0] KIND_STYLE  = 2'd2;

    typedef enum logic [2:0] {
        MODE_PLAIN        = 3'd0,
        MODE_TAGSTART     = 3'd1,
        MODE_ORDTAG       = 3'd2,
        MODE_BLOCK_BQ     = 3'd3,
        MODE_BLOCK_SCRIPT = 3'd4,
        MODE_BLOCK_STYLE  = 3'd5
    } scan_mode_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH_READ,
        ST_FLUSH_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic step;
        logic rd_issue;
        logic send_flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic flush_needed;
        logic flush_last;
    } dp_status_t;

    function automatic logic [3:0] opener_len(input logic [1:0] k);
        logic [3:0] len;
        len = 4'd0;
        unique case (k)
            KIND_BQ:     len = 4'd11;
            KIND_SCRIPT: len = 4'd7;
            KIND_STYLE:  len = 4'd6;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] closer_len(input logic [1:0] k);
        logic [3:0] len;
        len = 4'd0;
        unique case (k)
            KIND_BQ:     len = 4'd13;
            KIND_SCRIPT: len = 4'd9;
            KIND_STYLE:  len = 4'd8;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

    // character at position p, first character at p = 0; zero past the end
    function automatic logic [7:0] opener_char(input logic [1:0] k, input logic [3:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (k)
            KIND_BQ:     if (p < 4'd11) ch = OPENER_BQ[8*(10-int'(p)) +: 8];
            KIND_SCRIPT: if (p < 4'd7)  ch = OPENER_SCRIPT[8*(6-int'(p)) +: 8];
            KIND_STYLE:  if (p < 4'd6)  ch = OPENER_STYLE[8*(5-int'(p)) +: 8];
            default:     ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] closer_char(input logic [1:0] k, input logic [3:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (k)
            KIND_BQ:     if (p < 4'd13) ch = CLOSER_BQ[8*(12-int'(p)) +: 8];
            KIND_SCRIPT: if (p < 4'd9)  ch = CLOSER_SCRIPT[8*(8-int'(p)) +: 8];
            KIND_STYLE:  if (p < 4'd8)  ch = CLOSER_STYLE[8*(7-int'(p)) +: 8];
            default:     ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic scan_mode_t kind_mode(input logic [1:0] k);
        scan_mode_t m;
        m = MODE_BLOCK_BQ;
        unique case (k)
            KIND_BQ:     m = MODE_BLOCK_BQ;
            KIND_SCRIPT: m = MODE_BLOCK_SCRIPT;
            KIND_STYLE:  m = MODE_BLOCK_STYLE;
            default:     m = MODE_BLOCK_BQ;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] mode_kind(input scan_mode_t m);
        logic [1:0] k;
        k = KIND_BQ;
        unique case (m)
            MODE_BLOCK_SCRIPT: k = KIND_SCRIPT;
            MODE_BLOCK_STYLE:  k = KIND_STYLE;
            default:           k = KIND_BQ;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### hdl/hts_ctrl.sv
// controller of the html tag stripper: run / flush sequencing
// depends on hts_pkg
`default_nettype none

module hts_ctrl
    import hts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire dp_status_t status,
    output logic            in_ready,
    output ctrl_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (in_valid && status.out_free && status.flush_needed)
                begin
                    state_next = ST_FLUSH_READ;
                end
            end
            ST_FLUSH_READ:
            begin
                state_next = ST_FLUSH_SEND;
            end
            ST_FLUSH_SEND:
            begin
                if (status.out_free)
                begin
                    state_next = status.flush_last ? ST_RUN : ST_FLUSH_READ;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd.step       = 1'b0;
        cmd.rd_issue   = 1'b0;
        cmd.send_flush = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                in_ready = status.out_free;
                cmd.step = in_valid && status.out_free;
            end
            ST_FLUSH_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_FLUSH_SEND:
            begin
                cmd.send_flush = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/hts_datapath.sv
// datapath of the html tag stripper: scan state, tag buffer, output register
// depends on hts_pkg; commanded by hts_ctrl
`default_nettype none

module hts_datapath
    import hts_pkg::*;
#(
    parameter int PENDING_DEPTH = 63
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctrl_cmd_t  cmd,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    output dp_status_t      status,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            last_of_text,
    output logic            tag_overflow
);

    localparam int AW = $clog2(PENDING_DEPTH);
    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);

    scan_mode_t    mode_reg, mode_next;
    logic [2:0]    cand_reg, cand_next;
    logic [3:0]    pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] idx_reg;

    logic [7:0]    pend_mem [PENDING_DEPTH];
    logic [7:0]    rd_data_reg;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [2:0]    alive;
    logic          done;
    scan_mode_t    done_mode;
    logic [1:0]    blk;
    logic          plain_res;
    logic          marker_res;
    logic          flush_needed;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          byte_valid_reg;
    logic          last_reg;
    logic          ovf_out_reg;

    always_comb
    begin
        mode_next = mode_reg;
        cand_next = cand_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        mem_we    = 1'b0;
        mem_addr  = cnt_reg[AW-1:0];
        alive     = 3'b000;
        done      = 1'b0;
        done_mode = MODE_BLOCK_BQ;
        blk       = mode_kind(mode_reg);

        unique case (mode_reg)
            MODE_PLAIN:
            begin
                if (text_byte == CHAR_LT)
                begin
                    mode_next = MODE_TAGSTART;
                    cand_next = 3'b111;
                    pos_next  = 4'd1;
                    mem_we    = 1'b1;
                    mem_addr  = '0;
                    cnt_next  = CW'(1);
                    ovf_next  = 1'b0;
                end
            end
            MODE_TAGSTART, MODE_ORDTAG:
            begin
                // hold the byte while room is left
                if (cnt_reg < DEPTH_C)
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                if (mode_reg == MODE_ORDTAG)
                begin
                    if (text_byte == CHAR_GT)
                    begin
                        mem_we    = 1'b0;
                        mode_next = MODE_PLAIN;
                        cnt_next  = '0;
                        ovf_next  = 1'b0;
                    end
                end
                else
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        if (cand_reg[c] && (pos_reg < opener_len(2'(c))) &&
                            (opener_char(2'(c), pos_reg) == text_byte))
                        begin
                            alive[c] = 1'b1;
                            if (pos_reg + 4'd1 == opener_len(2'(c)))
                            begin
                                done      = 1'b1;
                                done_mode = kind_mode(2'(c));
                            end
                        end
                    end
                    cand_next = alive;
                    pos_next  = pos_reg + 4'd1;
                    if (done)
                    begin
                        mode_next = done_mode;
                        pos_next  = 4'd0;
                        cnt_next  = '0;
                        ovf_next  = 1'b0;
                    end
                    else if (alive == 3'b000)
                    begin
                        if (text_byte == CHAR_GT)
                        begin
                            mode_next = MODE_PLAIN;
                            cnt_next  = '0;
                            ovf_next  = 1'b0;
                        end
                        else
                        begin
                            mode_next = MODE_ORDTAG;
                        end
                    end
                end
            end
            MODE_BLOCK_BQ, MODE_BLOCK_SCRIPT, MODE_BLOCK_STYLE:
            begin
                if ((pos_reg < closer_len(blk)) && (closer_char(blk, pos_reg) == text_byte))
                begin
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg + 4'd1 == closer_len(blk))
                    begin
                        mode_next = MODE_PLAIN;
                        pos_next  = 4'd0;
                    end
                end
                else
                begin
                    pos_next = (text_byte == CHAR_LT) ? 4'd1 : 4'd0;
                end
            end
            default:
            begin
                mode_next = MODE_PLAIN;
            end
        endcase

        plain_res    = (mode_reg == MODE_PLAIN) && (text_byte != CHAR_LT);
        flush_needed = end_of_text &&
                       ((mode_next == MODE_TAGSTART) || (mode_next == MODE_ORDTAG));
        marker_res   = end_of_text && !plain_res && !flush_needed;

        // end of text: scan state back to reset, held bytes kept for the flush
        if (end_of_text)
        begin
            mode_next = MODE_PLAIN;
            cand_next = 3'b111;
            pos_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_PLAIN;
            cand_reg      <= 3'b111;
            pos_reg       <= 4'd0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.step)
            begin
                mode_reg <= mode_next;
                cand_reg <= cand_next;
                pos_reg  <= pos_next;
                cnt_reg  <= cnt_next;
                ovf_reg  <= ovf_next;
                idx_reg  <= '0;
            end
            else if (cmd.send_flush)
            begin
                idx_reg <= idx_reg + AW'(1);
            end

            if ((cmd.step && (plain_res || marker_res)) || cmd.send_flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // tag buffer and its registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.step && mem_we)
        begin
            pend_mem[mem_addr] <= text_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= pend_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.send_flush)
        begin
            out_byte_reg   <= rd_data_reg;
            byte_valid_reg <= 1'b1;
            last_reg       <= status.flush_last;
            ovf_out_reg    <= ovf_reg;
        end
        else if (cmd.step)
        begin
            out_byte_reg   <= plain_res ? text_byte : 8'h00;
            byte_valid_reg <= plain_res;
            last_reg       <= end_of_text;
            ovf_out_reg    <= 1'b0;
        end
    end

    assign status.out_free     = !out_valid_reg || out_ready;
    assign status.flush_needed = flush_needed;
    assign status.flush_last   = ((CW'(idx_reg) + CW'(1)) == cnt_reg);

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign byte_valid   = byte_valid_reg;
    assign last_of_text = last_reg;
    assign tag_overflow = ovf_out_reg;

endmodule

`default_nettype wire

### hdl/html_tag_stripper.sv
// html tag stripper top level: byte stream in, stripped text stream out
// a kept byte reaches the master side in the cycle after its request
// throughput: one byte per cycle, tags too, while scanning and m_tready allows
// end of text inside an open tag that starts no block flushes the held bytes,
// each by a registered read of the tag buffer followed by the output load
// reset: rst_n clears scan state and output valid; the tag buffer is not cleared
`default_nettype none

module html_tag_stripper
    import hts_pkg::*;
#(
    parameter int PENDING_DEPTH = 63
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // slave side: one text byte per request
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tlast,   // end_of_text
    // master side: stripped text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // last_of_text
    output logic [1:0]      m_tuser    // [0] byte_valid, [1] tag_overflow
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // controller: decides when a request is taken and sequences the flush
    hts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // datapath: opener/closer matching, held tag bytes, output register
    hts_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .text_byte    (s_tdata),
        .end_of_text  (s_tlast),
        .status       (status),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_byte     (m_tdata),
        .byte_valid   (m_tuser[0]),
        .last_of_text (m_tlast),
        .tag_overflow (m_tuser[1])
    );

    // no new request is taken once a flush has been triggered
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && status.flush_needed) |=> !s_tready)
        else $error("request taken during end-of-text flush");

    // a flushed byte always lands in the output register as a real character
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.send_flush |=> (m_tvalid && m_tuser[0]))
        else $error("flushed byte not presented");

    // a bare end marker carries a zero byte, no overflow, and closes the text
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata == 8'h00) && !m_tuser[1]))
        else $error("malformed end marker");

    // commands to the datapath never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.step, cmd.rd_issue, cmd.send_flush}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire
